// ----- rtl/pasv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pasv_pkg
// Types, constants and tables shared by the polyphonic synth voice bank.
// ----------------------------------------------------------------------------
package pasv_pkg;

	localparam int ENV_W = 25;

	typedef enum logic {
		OP_SET  = 1'b0,
		OP_TICK = 1'b1
	} pasv_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} pasv_state_t;

	// register index decoded from paddr[2]
	localparam logic REG_PRESET = 1'b0;

	typedef struct packed {
		logic signed [7:0] note;
		logic              gate;
		logic [10:0]       vel;
	} pasv_ctrl_t;

	typedef struct packed {
		logic [ENV_W-1:0]  env;
		logic [31:0]       phase;
		logic signed [7:0] latched;
	} pasv_voice_t;

	localparam logic signed [7:0] NOTE_NONE = 8'shFF;
	localparam logic [ENV_W-1:0]  ENV_FULL  = 25'h100_0000;
	localparam logic [ENV_W-1:0]  ENV_DEAD  = 25'd1677;
	localparam logic [10:0]       VEL_FULL  = 11'd1024;
	localparam logic [12:0]       GAIN_Q16  = 13'd6554;

	localparam pasv_ctrl_t  CTRL_RESET  = '{note: NOTE_NONE, gate: 1'b0, vel: 11'd0};
	localparam pasv_voice_t VOICE_RESET = '{env: '0, phase: 32'd0, latched: NOTE_NONE};

	// envelope times in ms
	localparam int ATT_MS_PLUCK = 8;
	localparam int REL_MS_PLUCK = 220;
	localparam int ATT_MS_PAD   = 160;
	localparam int REL_MS_PAD   = 850;

	// harmonic weights, Q0.15
	localparam logic [14:0] W1_PLUCK = 15'd25559;
	localparam logic [14:0] W2_PLUCK = 15'd5243;
	localparam logic [14:0] W3_PLUCK = 15'd1966;
	localparam logic [14:0] W1_PAD   = 15'd24904;
	localparam logic [14:0] W2_PAD   = 15'd5571;
	localparam logic [14:0] W3_PAD   = 15'd2294;

	localparam int NOTE_COUNT = 128;

	// top octave pitches in milli-hertz
	localparam logic [23:0] TOP_OCT_MHZ [12] = '{
		24'd8372018, 24'd8869844, 24'd9397273, 24'd9956063,
		24'd10548082, 24'd11175303, 24'd11839822, 24'd12543854,
		24'd13289750, 24'd14080000, 24'd14917240, 24'd15804266
	};

	// cycles from the last voice read until the sum holds every voice
	localparam int DRAIN_CYCLES = 9;
	localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

	// quarter-wave sine, 17 points, Q0.15
	function automatic logic [14:0] qsine(input logic [4:0] i);
		logic [14:0] v;
		case (i)
			5'd0:    v = 15'd0;
			5'd1:    v = 15'd3212;
			5'd2:    v = 15'd6393;
			5'd3:    v = 15'd9512;
			5'd4:    v = 15'd12540;
			5'd5:    v = 15'd15447;
			5'd6:    v = 15'd18205;
			5'd7:    v = 15'd20788;
			5'd8:    v = 15'd23170;
			5'd9:    v = 15'd25330;
			5'd10:   v = 15'd27246;
			5'd11:   v = 15'd28899;
			5'd12:   v = 15'd30274;
			5'd13:   v = 15'd31357;
			5'd14:   v = 15'd32138;
			5'd15:   v = 15'd32610;
			default: v = 15'd32767;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pasv_sine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pasv_sine
// Two-stage sine lookup: quarter-wave table with linear interpolation.
// ----------------------------------------------------------------------------
module pasv_sine
	import pasv_pkg::*;
(
	input  logic               clk,
	input  logic [31:0]        phase,
	output logic signed [15:0] sine
);

	logic [19:0] x;
	logic [20:0] xm;
	logic [4:0]  idx;
	logic [14:0] base;
	logic [11:0] diff;

	logic [14:0] base_s1;
	logic [11:0] diff_s1;
	logic [15:0] frac_s1;
	logic        neg_s1;

	logic [27:0] prod;
	logic [14:0] mag;

	logic signed [15:0] sine_s2;

	always_comb begin
		x  = phase[29:10];
		// odd quadrants run the table backward
		xm = phase[30] ? (21'h10_0000 - {1'b0, x}) : {1'b0, x};
		idx = xm[20:16];
		if (idx >= 5'd16) begin
			base = qsine(5'd16);
			diff = 12'd0;
		end else begin
			base = qsine(idx);
			diff = 12'(qsine(idx + 5'd1) - qsine(idx));
		end
	end

	always_ff @(posedge clk) begin
		base_s1 <= base;
		diff_s1 <= diff;
		frac_s1 <= xm[15:0];
		neg_s1  <= phase[31];
	end

	always_comb begin
		prod = diff_s1 * frac_s1;
		mag  = base_s1 + 15'(prod[27:16]);
	end

	always_ff @(posedge clk) begin
		sine_s2 <= neg_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	assign sine = sine_s2;

endmodule
`default_nettype wire

// ----- rtl/polyphonic_additive_synth_voice_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_additive_synth_voice_top
// Polyphonic sine voice bank with linear envelopes and one summed sample per tick.
// ----------------------------------------------------------------------------
// A set-voice beat (tuser low) writes one voice's note, gate and velocity in the
// cycle it is accepted. A tick beat (tuser high) walks the voices through one
// voice-state memory read port, one voice per cycle, into a 9-deep arithmetic
// pipeline (sine lookups, harmonic mix, envelope and velocity scaling); the block
// stays busy in its run, drain and done states after a tick is accepted and then
// hands the saturated sample to the output register, where it may wait while the
// next beat is taken. All voice state is cleared at reset through per-entry valid
// bits, so no clearing pass is needed.
module polyphonic_additive_synth_voice_top
	import pasv_pkg::*;
#(
	parameter int VOICES      = 8,
	parameter int SAMPLE_RATE = 48000
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        s_tvalid,
	output logic        s_tready,
	// voice_index[2:0], note_number[10:3], gate_on[11], velocity[22:12], zero[23]
	input  logic [23:0] s_tdata,
	// operation[0]
	input  logic        s_tuser,

	output logic        m_tvalid,
	input  logic        m_tready,
	// sample[15:0]
	output logic [15:0] m_tdata
);

	localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW    = 14;
	localparam int SUM_W = CW + VIW + 3;

	localparam logic [63:0] ENV_NUM  = 64'(ENV_FULL) * 64'd1000;
	localparam logic [63:0] DEN_AT0  = 64'(ATT_MS_PLUCK) * 64'(SAMPLE_RATE);
	localparam logic [63:0] DEN_RE0  = 64'(REL_MS_PLUCK) * 64'(SAMPLE_RATE);
	localparam logic [63:0] DEN_AT1  = 64'(ATT_MS_PAD) * 64'(SAMPLE_RATE);
	localparam logic [63:0] DEN_RE1  = 64'(REL_MS_PAD) * 64'(SAMPLE_RATE);
	localparam logic [63:0] ATT0_L   = (ENV_NUM + DEN_AT0 / 2) / DEN_AT0;
	localparam logic [63:0] REL0_L   = (ENV_NUM + DEN_RE0 / 2) / DEN_RE0;
	localparam logic [63:0] ATT1_L   = (ENV_NUM + DEN_AT1 / 2) / DEN_AT1;
	localparam logic [63:0] REL1_L   = (ENV_NUM + DEN_RE1 / 2) / DEN_RE1;
	localparam logic [ENV_W-1:0] ATT0 = ATT0_L[ENV_W-1:0];
	localparam logic [ENV_W-1:0] REL0 = REL0_L[ENV_W-1:0];
	localparam logic [ENV_W-1:0] ATT1 = ATT1_L[ENV_W-1:0];
	localparam logic [ENV_W-1:0] REL1 = REL1_L[ENV_W-1:0];

	localparam logic [63:0] PH_DEN = 64'd1000 * 64'(SAMPLE_RATE);

	localparam logic signed [63:0]      RND_HALF = 64'sd562949953421312;
	localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SUM_MIN  = SUM_W'(-32768);

	// phase increment per note
	logic [31:0] inc_tab [NOTE_COUNT];
	for (genvar n = 0; n < NOTE_COUNT; n++) begin : g_inc
		localparam logic [63:0] NUM = (64'(TOP_OCT_MHZ[n % 12]) << 32) >> (10 - n / 12);
		localparam logic [63:0] INC = (NUM + PH_DEN / 2) / PH_DEN;
		assign inc_tab[n] = INC[31:0];
	end

	// configuration
	logic preset_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == REG_PRESET) begin
			preset_q <= pwdata[0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PRESET: prdata = {31'd0, preset_q};
			default:    prdata = 32'd0;
		endcase
	end

	// input beat fields
	pasv_op_t          in_op;
	logic [2:0]        in_idx;
	logic signed [7:0] in_note;
	logic              in_gate;
	logic [10:0]       in_vel;

	assign in_op   = pasv_op_t'(s_tuser);
	assign in_idx  = s_tdata[2:0];
	assign in_note = s_tdata[10:3];
	assign in_gate = s_tdata[11];
	assign in_vel  = s_tdata[22:12];

	// sequencer
	pasv_state_t        state_q, state_d;
	logic [VIW-1:0]     cnt_q;
	logic [DRAIN_W-1:0] dcnt_q;
	logic               issue;
	logic               out_load;
	logic               in_acc;
	logic               tick_acc;
	logic               m_tvalid_q;

	assign in_acc   = s_tvalid && s_tready;
	assign tick_acc = in_acc && in_op == OP_TICK;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (tick_acc) state_d = ST_RUN;
			ST_RUN:   if (cnt_q == VIW'(VOICES - 1)) state_d = ST_DRAIN;
			ST_DRAIN: if (dcnt_q == DRAIN_W'(DRAIN_CYCLES - 1)) state_d = ST_DONE;
			ST_DONE:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_RUN:   issue = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  out_load = !m_tvalid_q || m_tready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (tick_acc) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (issue) begin
				dcnt_q <= '0;
			end else if (state_q == ST_DRAIN) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	// control memory, written by set-voice beats
	pasv_ctrl_t     ct_mem [VOICES];
	logic [VOICES-1:0] ct_vld_q;
	logic           ct_we;
	logic [VIW-1:0] ct_wa;
	pasv_ctrl_t     ct_wd;
	pasv_ctrl_t     ct_rd_s1;
	logic           ct_hit_s1;

	assign ct_we      = in_acc && in_op == OP_SET && ({29'd0, in_idx} < 32'(VOICES));
	assign ct_wa      = VIW'(in_idx);
	assign ct_wd.note = in_note[7] ? NOTE_NONE : in_note;
	assign ct_wd.gate = in_gate;
	assign ct_wd.vel  = (in_vel > VEL_FULL) ? VEL_FULL : in_vel;

	always_ff @(posedge clk) begin
		if (ct_we) begin
			ct_mem[ct_wa] <= ct_wd;
		end
		ct_rd_s1 <= ct_mem[cnt_q];
	end

	// voice state memory, read-modify-write per tick
	pasv_voice_t    st_mem [VOICES];
	logic [VOICES-1:0] st_vld_q;
	logic           st_we;
	pasv_voice_t    st_wd;
	pasv_voice_t    st_rd_s1;
	logic           st_hit_s1;

	logic           vld_s1;
	logic [VIW-1:0] v_s1;
	logic [VIW-1:0] v_s2;

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[v_s2] <= st_wd;
		end
		st_rd_s1 <= st_mem[cnt_q];
		v_s1     <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_vld_q  <= '0;
			st_vld_q  <= '0;
			ct_hit_s1 <= 1'b0;
			st_hit_s1 <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			if (ct_we) begin
				ct_vld_q[ct_wa] <= 1'b1;
			end
			if (st_we) begin
				st_vld_q[v_s2] <= 1'b1;
			end
			ct_hit_s1 <= ct_vld_q[cnt_q];
			st_hit_s1 <= st_vld_q[cnt_q];
			vld_s1    <= issue;
		end
	end

	// stage 1: envelope step and note latch
	pasv_ctrl_t       ctl;
	pasv_voice_t      vs;
	logic [ENV_W-1:0] att;
	logic [ENV_W-1:0] rel;
	logic [ENV_W:0]   env_sum;
	logic [ENV_W-1:0] env_n;
	logic             note_neg;
	logic             skip;
	logic             new_note;
	logic             silent;

	always_comb begin
		ctl      = ct_hit_s1 ? ct_rd_s1 : CTRL_RESET;
		vs       = st_hit_s1 ? st_rd_s1 : VOICE_RESET;
		att      = preset_q ? ATT1 : ATT0;
		rel      = preset_q ? REL1 : REL0;
		note_neg = ctl.note[7];
		skip     = note_neg && vs.env <= ENV_DEAD;
		new_note = !note_neg && ctl.note != vs.latched;
		env_sum  = {1'b0, vs.env} + {1'b0, att};
		if (ctl.gate) begin
			env_n = (env_sum > {1'b0, ENV_FULL}) ? ENV_FULL : env_sum[ENV_W-1:0];
		end else begin
			env_n = (vs.env > rel) ? vs.env - rel : '0;
		end
		silent = env_n <= ENV_DEAD || note_neg;
	end

	logic              wr_s2;
	logic              act_s2;
	logic [ENV_W-1:0]  env_s2;
	logic [31:0]       ph_s2;
	logic signed [7:0] lat_s2;
	logic [6:0]        note_s2;
	logic [10:0]       vel_s2;

	always_ff @(posedge clk) begin
		v_s2    <= v_s1;
		env_s2  <= env_n;
		ph_s2   <= new_note ? 32'd0 : vs.phase;
		lat_s2  <= new_note ? ctl.note : vs.latched;
		note_s2 <= ctl.note[6:0];
		vel_s2  <= ctl.vel;
	end

	// stage 2: write back and harmonic phases
	logic [31:0] ph_next;
	logic [31:0] pc;

	always_comb begin
		ph_next = act_s2 ? ph_s2 + inc_tab[note_s2] : ph_s2;
		st_we   = wr_s2;
		st_wd   = '{env: env_s2, phase: ph_next, latched: lat_s2};
		// pad takes the subharmonic, plucky the third harmonic
		pc      = preset_q ? {1'b0, ph_s2[31:1]} : ph_s2 + {ph_s2[30:0], 1'b0};
	end

	logic [31:0] pa_s3;
	logic [31:0] pb_s3;
	logic [31:0] pc_s3;
	logic [35:0] ev_s3;

	always_ff @(posedge clk) begin
		pa_s3 <= ph_s2;
		pb_s3 <= {ph_s2[30:0], 1'b0};
		pc_s3 <= pc;
		ev_s3 <= env_s2 * vel_s2;
	end

	// stages 3 and 4: sine lookups
	logic signed [15:0] sin_a_s5;
	logic signed [15:0] sin_b_s5;
	logic signed [15:0] sin_c_s5;

	pasv_sine u_sin_a (.clk(clk), .phase(pa_s3), .sine(sin_a_s5));
	pasv_sine u_sin_b (.clk(clk), .phase(pb_s3), .sine(sin_b_s5));
	pasv_sine u_sin_c (.clk(clk), .phase(pc_s3), .sine(sin_c_s5));

	logic [48:0] evg_s4;
	logic [48:0] evg_s5;
	logic [48:0] evg_s6;
	logic [48:0] evg_s7;

	always_ff @(posedge clk) begin
		evg_s4 <= ev_s3 * GAIN_Q16;
		evg_s5 <= evg_s4;
		evg_s6 <= evg_s5;
		evg_s7 <= evg_s6;
	end

	// stage 5: harmonic weights
	logic [14:0] wa;
	logic [14:0] wb;
	logic [14:0] wc;

	always_comb begin
		wa = preset_q ? W1_PAD : W1_PLUCK;
		wb = preset_q ? W2_PAD : W2_PLUCK;
		wc = preset_q ? W3_PAD : W3_PLUCK;
	end

	logic signed [31:0] wa_s6;
	logic signed [31:0] wb_s6;
	logic signed [31:0] wc_s6;

	always_ff @(posedge clk) begin
		wa_s6 <= $signed({1'b0, wa}) * sin_a_s5;
		wb_s6 <= $signed({1'b0, wb}) * sin_b_s5;
		wc_s6 <= $signed({1'b0, wc}) * sin_c_s5;
	end

	// stage 6: mix, floored to Q1.15
	logic signed [33:0] mix;
	logic signed [16:0] wave_s7;

	assign mix = 34'(wa_s6) + 34'(wb_s6) + 34'(wc_s6);

	always_ff @(posedge clk) begin
		wave_s7 <= mix[31:15];
	end

	// stage 7: wave times scale, split in two partial products
	logic signed [41:0] plo_s8;
	logic signed [42:0] phi_s8;

	always_ff @(posedge clk) begin
		plo_s8 <= wave_s7 * $signed({1'b0, evg_s7[23:0]});
		phi_s8 <= wave_s7 * $signed({1'b0, evg_s7[48:24]});
	end

	// stage 8: combine and round half up
	logic signed [63:0] prod;
	logic signed [CW-1:0] contrib_s9;

	assign prod = (64'(phi_s8) <<< 24) + 64'(plo_s8) + RND_HALF;

	always_ff @(posedge clk) begin
		contrib_s9 <= prod[63:50];
	end

	// activity chain, resets with the control state
	logic act_s3;
	logic act_s4;
	logic act_s5;
	logic act_s6;
	logic act_s7;
	logic act_s8;
	logic act_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s2  <= 1'b0;
			act_s2 <= 1'b0;
			act_s3 <= 1'b0;
			act_s4 <= 1'b0;
			act_s5 <= 1'b0;
			act_s6 <= 1'b0;
			act_s7 <= 1'b0;
			act_s8 <= 1'b0;
			act_s9 <= 1'b0;
		end else begin
			wr_s2  <= vld_s1 && !skip;
			act_s2 <= vld_s1 && !skip && !silent;
			act_s3 <= act_s2;
			act_s4 <= act_s3;
			act_s5 <= act_s4;
			act_s6 <= act_s5;
			act_s7 <= act_s6;
			act_s8 <= act_s7;
			act_s9 <= act_s8;
		end
	end

	// accumulator and output register
	logic signed [SUM_W-1:0] sum_q;
	logic [15:0]             sat;
	logic [15:0]             m_tdata_q;

	always_comb begin
		if (sum_q > SUM_MAX) begin
			sat = 16'h7FFF;
		end else if (sum_q < SUM_MIN) begin
			sat = 16'h8000;
		end else begin
			sat = sum_q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				sum_q <= '0;
			end else if (act_s9) begin
				sum_q <= sum_q + SUM_W'(contrib_s9);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_tick_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> state_q == ST_RUN && cnt_q == '0)
		else $error("tick beat did not start the voice walk at voice zero");

	a_wb_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("voice state written outside a tick");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !vld_s1 && !act_s2 && !act_s9 && !wr_s2)
		else $error("pipeline still active while idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the done state");

endmodule
`default_nettype wire

// ----- bench/polyphonic_additive_synth_voice_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_additive_synth_voice_top_test
// Self-checking bench for the polyphonic synth voice bank. Set-voice and tick
// beats go in on the input stream, and each tick is run through a bit-exact
// model of the voice bank kept here. Every output beat is compared with the
// oldest predicted sample. Both presets are exercised, and both stream sides
// stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module polyphonic_additive_synth_voice_top_test;
	import pasv_pkg::*;

	localparam int N_VOICES      = 8;
	localparam int FS            = 48000;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SQUEEZE_AT    = 100;
	localparam int SQUEEZE_LEN   = 300;

	localparam logic [2:0] PRESET_ADDR = {REG_PRESET, 2'b00};

	localparam int unsigned QUARTER [17] = '{
		0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
		25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767
	};

	typedef struct packed {
		pasv_op_t    op;
		logic [2:0]  voice;
		logic [7:0]  note;
		logic        gate;
		logic [10:0] vel;
	} beat_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// voice_index[2:0], note_number[10:3], gate_on[11], velocity[22:12], zero[23]
	logic [23:0] s_tdata  = '0;
	// operation[0]
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// sample[15:0]
	logic [15:0] m_tdata;

	beat_t       beats_to_send [$];
	logic [15:0] expected_samples [$];

	// voice bank model state
	logic [24:0]       env_lvl     [N_VOICES];
	logic [31:0]       acc_phase   [N_VOICES];
	logic signed [7:0] pitch_latch [N_VOICES];
	logic signed [7:0] note_held   [N_VOICES];
	logic              gate_held   [N_VOICES];
	logic [10:0]       vel_held    [N_VOICES];
	logic              pad_mode = 1'b0;

	logic calm     = 1'b0;
	logic squeezed = 1'b0;
	int   beats_in = 0;
	int   s_gap    = 0;
	int   m_hold   = 0;
	int   quiet    = 0;
	int   mismatches = 0;

	polyphonic_additive_synth_voice_top #(
		.VOICES(N_VOICES),
		.SAMPLE_RATE(FS)
	) uut (.*);

	always #10 clk = ~clk;

	function automatic logic [24:0] ramp_step(input int ms);
		longint unsigned den;
		den = longint'(ms) * FS;
		return 25'((longint'(ENV_FULL) * 1000 + den / 2) / den);
	endfunction

	function automatic logic [31:0] pitch_step(input logic [6:0] n);
		longint unsigned num;
		longint unsigned den;
		num = {TOP_OCT_MHZ[n % 12], 32'd0};
		num = num >> (10 - n / 12);
		den = longint'(FS) * 1000;
		return 32'((num + den / 2) / den);
	endfunction

	// quarter-wave table with truncated linear interpolation
	function automatic int sine_at(input logic [31:0] ph);
		logic [20:0] x;
		int unsigned rise;
		int unsigned mag;
		x = {1'b0, ph[29:10]};
		if (ph[30]) x = 21'h10_0000 - x;
		if (x[20]) begin
			mag = QUARTER[16];
		end else begin
			rise = QUARTER[x[19:16] + 1] - QUARTER[x[19:16]];
			mag = QUARTER[x[19:16]] + ((rise * x[15:0]) >> 16);
		end
		return ph[31] ? -int'(mag) : int'(mag);
	endfunction

	task automatic clear_voices();
		for (int v = 0; v < N_VOICES; v++) begin
			env_lvl[v]     = '0;
			acc_phase[v]   = '0;
			pitch_latch[v] = NOTE_NONE;
			note_held[v]   = NOTE_NONE;
			gate_held[v]   = 1'b0;
			vel_held[v]    = '0;
		end
	endtask

	task automatic store_voice_controls(input logic [23:0] d);
		logic [10:0] vel;
		vel = d[22:12];
		note_held[d[2:0]] = d[10] ? NOTE_NONE : d[10:3];
		gate_held[d[2:0]] = d[11];
		vel_held[d[2:0]]  = (vel > VEL_FULL) ? VEL_FULL : vel;
	endtask

	task automatic render_tick();
		longint            mix;
		longint            wave;
		longint            prod;
		logic [25:0]       raised;
		logic [24:0]       up;
		logic [24:0]       down;
		logic [31:0]       ph;
		logic signed [7:0] nt;
		up   = ramp_step(pad_mode ? ATT_MS_PAD : ATT_MS_PLUCK);
		down = ramp_step(pad_mode ? REL_MS_PAD : REL_MS_PLUCK);
		mix  = 0;
		for (int v = 0; v < N_VOICES; v++) begin
			nt = note_held[v];
			// no note and a dead envelope: voice left alone
			if (nt < 0 && env_lvl[v] <= ENV_DEAD) continue;
			if (nt >= 0 && nt != pitch_latch[v]) begin
				pitch_latch[v] = nt;
				acc_phase[v]   = '0;
			end
			if (gate_held[v]) begin
				raised = env_lvl[v] + up;
				env_lvl[v] = (raised > ENV_FULL) ? ENV_FULL : raised[24:0];
			end else begin
				env_lvl[v] = (env_lvl[v] > down) ? env_lvl[v] - down : '0;
			end
			if (env_lvl[v] <= ENV_DEAD || nt < 0) continue;
			ph = acc_phase[v];
			if (pad_mode)
				wave = longint'(W1_PAD) * sine_at(ph) + longint'(W2_PAD) * sine_at(ph << 1) +
					longint'(W3_PAD) * sine_at(ph >> 1);
			else
				wave = longint'(W1_PLUCK) * sine_at(ph) + longint'(W2_PLUCK) * sine_at(ph << 1) +
					longint'(W3_PLUCK) * sine_at(ph * 32'd3);
			wave = wave >>> 15;
			prod = wave * longint'(env_lvl[v]) * longint'(vel_held[v]) * longint'(GAIN_Q16);
			mix += (prod + (longint'(1) << 49)) >>> 50;
			acc_phase[v] = ph + pitch_step(nt[6:0]);
		end
		if (mix > 32767) mix = 32767;
		if (mix < -32768) mix = -32768;
		expected_samples.push_back(mix[15:0]);
	endtask

	task automatic push_beat(input pasv_op_t op, input logic [2:0] vc, input logic [7:0] nt,
			input logic g, input logic [10:0] vl);
		beat_t b;
		b.op    = op;
		b.voice = vc;
		b.note  = nt;
		b.gate  = g;
		b.vel   = vl;
		beats_to_send.push_back(b);
	endtask

	// mostly ticks and well-formed note on/off, some raw noise;
	// with hold_lead voice 0 never releases so its attack reaches full scale
	task automatic queue_random(input int count, input bit hold_lead);
		int         pick;
		logic [2:0] vc;
		logic       g;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			vc   = 3'($urandom);
			if (pick < 80) begin
				push_beat(OP_TICK, vc, 8'($urandom), 1'($urandom), 11'($urandom));
			end else if (pick < 95) begin
				g = ($urandom_range(0, 2) != 0) || (hold_lead && vc == 3'd0);
				if (g)
					push_beat(OP_SET, vc, 8'($urandom_range(0, 127)), 1'b1,
						11'($urandom_range(1, 1024)));
				else
					push_beat(OP_SET, vc,
						$urandom_range(0, 1) ? NOTE_NONE : 8'($urandom_range(0, 127)),
						1'b0, 11'($urandom_range(1, 1024)));
			end else begin
				push_beat(OP_SET, vc, 8'($urandom),
					(hold_lead && vc == 3'd0) ? 1'b1 : 1'($urandom), 11'($urandom));
			end
		end
	endtask

	task automatic queue_directed();
		push_beat(OP_TICK, 3'd7, 8'h7F, 1'b1, 11'h7FF);	// whole bank idle
		push_beat(OP_SET, 3'd0, 8'd69, 1'b1, 11'd1024);
		push_beat(OP_SET, 3'd7, 8'd127, 1'b1, 11'd2047);	// velocity clamps
		push_beat(OP_SET, 3'd1, 8'd0, 1'b1, 11'd1024);
		push_beat(OP_SET, 3'd2, NOTE_NONE, 1'b1, 11'd500);	// no note, never sounds
		push_beat(OP_SET, 3'd3, 8'h80, 1'b1, 11'd1);
		push_beat(OP_SET, 3'd4, 8'd60, 1'b1, 11'd0);
		repeat (3) push_beat(OP_TICK, '0, '0, 1'b0, '0);
		push_beat(OP_SET, 3'd1, 8'd0, 1'b0, 11'd1024);	// release, same pitch keeps phase
		push_beat(OP_SET, 3'd7, 8'd100, 1'b1, 11'd1024);	// new pitch restarts phase
		repeat (2) push_beat(OP_TICK, '0, '0, 1'b0, '0);
		push_beat(OP_SET, 3'd4, NOTE_NONE, 1'b0, 11'd0);	// decays without sound
		push_beat(OP_SET, 3'd2, 8'd55, 1'b0, 11'd1024);	// gate off from silence stays dead
		repeat (2) push_beat(OP_TICK, '0, '0, 1'b0, '0);
		push_beat(OP_SET, 3'd5, 8'd64, 1'b1, 11'd700);
		push_beat(OP_SET, 3'd6, 8'd12, 1'b1, 11'd1024);
		push_beat(OP_SET, 3'd3, 8'h7F, 1'b1, 11'd1023);
		repeat (3) push_beat(OP_TICK, '0, '0, 1'b0, '0);
	endtask

	task automatic write_preset(input logic pad);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PRESET_ADDR;
		pwdata  <= {31'd0, pad};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		pad_mode <= pad;
	endtask

	// checked at the falling edge so the feed process has settled
	task automatic settle();
		@(negedge clk);
		while (beats_to_send.size() != 0 || s_tvalid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// input feed; the model advances on each accepted beat
	always @(posedge clk or negedge arst_n) begin : feed
		beat_t nxt;
		logic  offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= OP_SET;
			s_gap    <= 0;
			beats_in <= 0;
			clear_voices();
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_TICK)
					render_tick();
				else
					store_voice_controls(s_tdata);
				beats_in <= beats_in + 1;
				offer = 1'b0;
			end
			if (!offer) begin
				if (s_gap > 0) begin
					s_gap <= s_gap - 1;
				end else if (beats_to_send.size() != 0) begin
					if (!calm && $urandom_range(0, 6) == 0) begin
						s_gap <= $urandom_range(1, 13);
					end else begin
						nxt = beats_to_send.pop_front();
						s_tdata <= {1'b0, nxt.vel, nxt.gate, nxt.note, nxt.voice};
						s_tuser <= nxt.op;
						offer = 1'b1;
					end
				end
			end
			s_tvalid <= offer;
		end
	end

	// output side stalls, plus one long hold-off to back up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_hold   <= 0;
			squeezed <= 1'b0;
		end else if (!squeezed && beats_in >= SQUEEZE_AT) begin
			squeezed <= 1'b1;
			m_hold   <= SQUEEZE_LEN;
			m_tready <= 1'b0;
		end else if (m_hold > 0) begin
			m_hold   <= m_hold - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			m_hold   <= $urandom_range(1, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected sample beat %h at %0t", m_tdata, $realtime);
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				if (m_tdata !== want) begin
					if (mismatches < 10)
						$display("sample: expected %0d got %0d at %0t",
							$signed(want), $signed(m_tdata), $realtime);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pwrite && pready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("polyphonic_additive_synth_voice_top: mismatch");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_preset(1'b0);
		@(negedge clk);
		queue_directed();
		queue_random(520, 1'b1);
		settle();

		write_preset(1'b1);
		@(negedge clk);
		queue_random(330, 1'b0);
		settle();

		// last stretch runs with no stalls on either side
		write_preset(1'b0);
		calm <= 1'b1;
		@(negedge clk);
		queue_random(180, 1'b0);
		settle();

		if (mismatches == 0)
			$display("polyphonic_additive_synth_voice_top: match");
		else
			$display("polyphonic_additive_synth_voice_top: mismatch");
		$finish;
	end

endmodule
